// ===== rtl/core/tvcc_pkg.sv =====
// Shared constants, types and the control store of the tilemap viewport core.
// Used by tvcc_div and tilemap_viewport_clamp_and_cull_core; depends on nothing.
`default_nettype none

package tvcc_pkg;

  // Geometry
  localparam int TILE_SIZE  = 32;
  localparam int FRAC_BITS  = 4;
  localparam int TILE_SHIFT = $clog2(TILE_SIZE) + FRAC_BITS;

  // Field and register widths
  localparam int SCREEN_W  = 12;
  localparam int TILES_W   = 8;
  localparam int ZOOM_W    = 12;
  localparam int CAM_OUT_W = 17;
  localparam int MAP_W     = TILES_W + TILE_SHIFT;
  localparam int CAM_W     = CAM_OUT_W + 1;
  localparam int AX_W      = 22;
  localparam int END_W     = AX_W - TILE_SHIFT;

  // Stream and configuration words
  localparam int BTN_COUNT   = 6;
  localparam int S_TDATA_W   = 8;
  localparam int M_FIELDS_W  = 2 * CAM_OUT_W + ZOOM_W + 4 * TILES_W;
  localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = SCREEN_W;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH_TILES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT_TILES = 3'd3;

  localparam logic [SCREEN_W-1:0] SCREEN_W_RESET = 12'd640;
  localparam logic [SCREEN_W-1:0] SCREEN_H_RESET = 12'd480;
  localparam logic [TILES_W-1:0]  MAP_TILES_RESET = 8'd50;

  // Button bit positions in the input word
  localparam int BTN_PAN_UP    = 0;
  localparam int BTN_PAN_DOWN  = 1;
  localparam int BTN_PAN_LEFT  = 2;
  localparam int BTN_PAN_RIGHT = 3;
  localparam int BTN_ZOOM_IN   = 4;
  localparam int BTN_ZOOM_OUT  = 5;

  // Pan and zoom arithmetic
  localparam logic [CAM_W-1:0] PAN_STEP = CAM_W'(5 << FRAC_BITS);
  localparam int MUL_K_W = 13;
  localparam int PROD_W  = ZOOM_W + MUL_K_W;
  localparam int ZQ_W    = PROD_W - 12;
  localparam logic [MUL_K_W-1:0] ZOOM_UP_MUL = 13'd4506;
  localparam logic [MUL_K_W-1:0] ZOOM_DN_MUL = 13'd3724;
  localparam logic [ZOOM_W-1:0]  ZOOM_MIN    = 12'd16;
  localparam logic [ZOOM_W-1:0]  ZOOM_MAX    = 12'd4095;
  localparam logic [ZOOM_W-1:0]  ZOOM_RESET  = 12'd256;

  // View divider: (screen << (8 + FRAC_BITS)) / zoom, two quotient bits a cycle
  localparam int DIV_W     = SCREEN_W + 8 + FRAC_BITS;
  localparam int VIEW_W    = DIV_W - 4;
  localparam int DIV_ITERS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  // Saturate a scaled zoom to its legal range
  function automatic logic [ZOOM_W-1:0] zoom_sat(input logic [ZQ_W-1:0] z);
    logic [ZOOM_W-1:0] r;
    if (z < ZQ_W'(ZOOM_MIN)) r = ZOOM_MIN;
    else if (z > ZQ_W'(ZOOM_MAX)) r = ZOOM_MAX;
    else r = z[ZOOM_W-1:0];
    return r;
  endfunction

  // Sequencer control word
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_PAN,
    OP_MUL_UP,
    OP_SAT_UP,
    OP_MUL_DN,
    OP_SAT_DN,
    OP_DIV,
    OP_CLAMP,
    OP_WINDOW,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    CND_NONE,
    CND_NO_INPUT,
    CND_DIV_BUSY,
    CND_OUT_FULL,
    CND_ALWAYS
  } cond_t;

  typedef struct packed {
    op_t   op;
    logic  axis;
    cond_t cond;
    step_t target;
  } uword_t;

  localparam logic AX_X = 1'b0;
  localparam logic AX_Y = 1'b1;

  localparam step_t L_IDLE   = 4'd0;
  localparam step_t L_WAIT_X = 4'd7;
  localparam step_t L_WAIT_Y = 4'd11;
  localparam step_t L_EMIT   = 4'd14;

  // Control store: a step whose condition holds jumps and skips its op
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    unique case (s)
      4'd0:  w = '{op: OP_TAKE,   axis: AX_X, cond: CND_NO_INPUT, target: L_IDLE};
      4'd1:  w = '{op: OP_PAN,    axis: AX_X, cond: CND_NONE,     target: L_IDLE};
      4'd2:  w = '{op: OP_MUL_UP, axis: AX_X, cond: CND_NONE,     target: L_IDLE};
      4'd3:  w = '{op: OP_SAT_UP, axis: AX_X, cond: CND_NONE,     target: L_IDLE};
      4'd4:  w = '{op: OP_MUL_DN, axis: AX_X, cond: CND_NONE,     target: L_IDLE};
      4'd5:  w = '{op: OP_SAT_DN, axis: AX_X, cond: CND_NONE,     target: L_IDLE};
      4'd6:  w = '{op: OP_DIV,    axis: AX_X, cond: CND_NONE,     target: L_IDLE};
      4'd7:  w = '{op: OP_NOP,    axis: AX_X, cond: CND_DIV_BUSY, target: L_WAIT_X};
      4'd8:  w = '{op: OP_CLAMP,  axis: AX_X, cond: CND_NONE,     target: L_IDLE};
      4'd9:  w = '{op: OP_WINDOW, axis: AX_X, cond: CND_NONE,     target: L_IDLE};
      4'd10: w = '{op: OP_DIV,    axis: AX_Y, cond: CND_NONE,     target: L_IDLE};
      4'd11: w = '{op: OP_NOP,    axis: AX_Y, cond: CND_DIV_BUSY, target: L_WAIT_Y};
      4'd12: w = '{op: OP_CLAMP,  axis: AX_Y, cond: CND_NONE,     target: L_IDLE};
      4'd13: w = '{op: OP_WINDOW, axis: AX_Y, cond: CND_NONE,     target: L_IDLE};
      4'd14: w = '{op: OP_EMIT,   axis: AX_X, cond: CND_OUT_FULL, target: L_EMIT};
      4'd15: w = '{op: OP_NOP,    axis: AX_X, cond: CND_ALWAYS,   target: L_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tvcc_div.sv =====
// Iterative restoring divider for the view size, two quotient bits per cycle.
// Depends on tvcc_pkg for its widths.
`default_nettype none

module tvcc_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [tvcc_pkg::DIV_W-1:0]     dividend,
  input  wire logic [tvcc_pkg::ZOOM_W-1:0]    divisor,
  output logic                                busy,
  output logic [tvcc_pkg::VIEW_W-1:0]         quotient
);

  logic [tvcc_pkg::DIV_W-1:0]     acc;
  logic [tvcc_pkg::DIV_W-1:0]     acc_next;
  logic [tvcc_pkg::ZOOM_W-1:0]    rem;
  logic [tvcc_pkg::ZOOM_W-1:0]    rem_next;
  logic [tvcc_pkg::ZOOM_W-1:0]    dv;
  logic [tvcc_pkg::DIV_CNT_W-1:0] count;

  logic [tvcc_pkg::ZOOM_W:0] t1;
  logic [tvcc_pkg::ZOOM_W:0] t2;
  logic [tvcc_pkg::ZOOM_W:0] r1;
  logic [tvcc_pkg::ZOOM_W:0] r2;
  logic                      ge1;
  logic                      ge2;

  // Two restoring steps: shift in a dividend bit, subtract where it fits
  always_comb begin
    t1 = {rem, acc[tvcc_pkg::DIV_W-1]};
    ge1 = (t1 >= {1'b0, dv});
    r1 = ge1 ? (t1 - {1'b0, dv}) : t1;
    t2 = {r1[tvcc_pkg::ZOOM_W-1:0], acc[tvcc_pkg::DIV_W-2]};
    ge2 = (t2 >= {1'b0, dv});
    r2 = ge2 ? (t2 - {1'b0, dv}) : t2;
    rem_next = r2[tvcc_pkg::ZOOM_W-1:0];
    acc_next = {acc[tvcc_pkg::DIV_W-3:0], ge1, ge2};
  end

  // Control: load on start, count down the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= tvcc_pkg::DIV_CNT_W'(tvcc_pkg::DIV_ITERS - 1);
    end else if (busy) begin
      if (count == '0) begin
        busy <= 1'b0;
      end else begin
        count <= count - 1'b1;
      end
    end
  end

  // Datapath: quotient bits shift in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dv  <= divisor;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quotient = acc[tvcc_pkg::VIEW_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/tilemap_viewport_clamp_and_cull_core.sv =====
// Tilemap viewport core: camera pan and zoom, clamp to the map, visible tile window.
// Depends on tvcc_pkg (constants, control store) and tvcc_div (view size divider).
//
// Use:
//   cfg_*     write channel; cfg_index 0..3 selects screen width, screen height,
//             map width in tiles, map height in tiles. Always ready; other
//             indexes are ignored. Write only while the core is idle.
//   s_axis_*  one word per frame carrying the six button flags.
//   m_axis_*  one word per frame: camera, zoom and the visible tile window.
// Each frame runs a 16-step microprogram. Two view-size divisions (one per axis,
// on a shared divider) set the time from the input word being taken to the result
// word being offered; the core takes no new input word before the previous frame
// has been loaded into the output register. s_axis_tready is high only while the
// sequencer sits at its first step.
// The result is held in an output register; if the receiver stalls, the core
// still takes and works the next frame and waits at its emit step until that
// register is free. Reset (rst, synchronous) restores the register defaults,
// puts the camera at zero and the zoom at 1.0, and empties the output.
`default_nettype none

module tilemap_viewport_clamp_and_cull_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tvcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tvcc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // button words
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pan_up, pan_down, pan_left, pan_right, zoom_in, zoom_out, 2 bits zero pad
  input  wire logic [tvcc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // view words
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // cam_x, cam_y, zoom_level, first_col, first_row, last_col, last_row,
  // 2 bits zero pad
  output logic [tvcc_pkg::M_TDATA_W-1:0]        m_axis_tdata
);

  // Configuration registers
  logic [tvcc_pkg::SCREEN_W-1:0] screen_width;
  logic [tvcc_pkg::SCREEN_W-1:0] screen_height;
  logic [tvcc_pkg::TILES_W-1:0]  map_width_tiles;
  logic [tvcc_pkg::TILES_W-1:0]  map_height_tiles;

  // Sequencer
  tvcc_pkg::step_t  step;
  tvcc_pkg::step_t  step_next;
  tvcc_pkg::uword_t uc;
  logic             cond_hit;
  logic             exec;

  // Datapath state
  logic [tvcc_pkg::BTN_COUNT-1:0]   btn;
  logic signed [tvcc_pkg::CAM_W-1:0] cam_x;
  logic signed [tvcc_pkg::CAM_W-1:0] cam_y;
  logic [tvcc_pkg::ZOOM_W-1:0]      zoom;
  logic [tvcc_pkg::PROD_W-1:0]      prod;
  logic [tvcc_pkg::TILES_W-1:0]     first_col;
  logic [tvcc_pkg::TILES_W-1:0]     first_row;
  logic [tvcc_pkg::TILES_W-1:0]     last_col;
  logic [tvcc_pkg::TILES_W-1:0]     last_row;

  // Divider
  logic                          div_start;
  logic                          div_busy;
  logic [tvcc_pkg::DIV_W-1:0]    div_dividend;
  logic [tvcc_pkg::VIEW_W-1:0]   div_quo;

  // Axis arithmetic
  logic signed [tvcc_pkg::CAM_W-1:0] cam_sel;
  logic [tvcc_pkg::TILES_W-1:0]      tiles_sel;
  logic signed [tvcc_pkg::AX_W-1:0]  cam_w;
  logic signed [tvcc_pkg::AX_W-1:0]  view_w;
  logic signed [tvcc_pkg::AX_W-1:0]  half_w;
  logic signed [tvcc_pkg::AX_W-1:0]  map_w;
  logic signed [tvcc_pkg::AX_W-1:0]  lo_w;
  logic signed [tvcc_pkg::AX_W-1:0]  hi_w;
  logic signed [tvcc_pkg::AX_W-1:0]  clamped;
  logic signed [tvcc_pkg::AX_W-1:0]  left_w;
  logic signed [tvcc_pkg::AX_W-1:0]  end_w;
  logic [tvcc_pkg::END_W-1:0]        end_tile;
  logic [tvcc_pkg::TILES_W-1:0]      first_new;
  logic [tvcc_pkg::TILES_W-1:0]      last_new;
  logic signed [tvcc_pkg::CAM_W-1:0] pan_dy;
  logic signed [tvcc_pkg::CAM_W-1:0] pan_dx;
  logic [tvcc_pkg::MUL_K_W-1:0]      mul_k;

  // Take configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width     <= tvcc_pkg::SCREEN_W_RESET;
      screen_height    <= tvcc_pkg::SCREEN_H_RESET;
      map_width_tiles  <= tvcc_pkg::MAP_TILES_RESET;
      map_height_tiles <= tvcc_pkg::MAP_TILES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tvcc_pkg::REG_SCREEN_WIDTH:     screen_width     <= cfg_data;
        tvcc_pkg::REG_SCREEN_HEIGHT:    screen_height    <= cfg_data;
        tvcc_pkg::REG_MAP_WIDTH_TILES:  map_width_tiles  <= cfg_data[tvcc_pkg::TILES_W-1:0];
        tvcc_pkg::REG_MAP_HEIGHT_TILES: map_height_tiles <= cfg_data[tvcc_pkg::TILES_W-1:0];
        default: ;
      endcase
    end
  end

  // Fetch the control word and resolve its jump condition
  assign uc = tvcc_pkg::ucode(step);

  always_comb begin
    unique case (uc.cond)
      tvcc_pkg::CND_NONE:     cond_hit = 1'b0;
      tvcc_pkg::CND_NO_INPUT: cond_hit = !s_axis_tvalid;
      tvcc_pkg::CND_DIV_BUSY: cond_hit = div_busy;
      tvcc_pkg::CND_OUT_FULL: cond_hit = m_axis_tvalid && !m_axis_tready;
      tvcc_pkg::CND_ALWAYS:   cond_hit = 1'b1;
      default:                cond_hit = 1'b0;
    endcase
    exec = !cond_hit;
    step_next = cond_hit ? uc.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= tvcc_pkg::L_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign s_axis_tready = (step == tvcc_pkg::L_IDLE);

  // Operand selection for the current axis
  assign cam_sel   = (uc.axis == tvcc_pkg::AX_Y) ? cam_y : cam_x;
  assign tiles_sel = (uc.axis == tvcc_pkg::AX_Y) ? map_height_tiles : map_width_tiles;

  // Start the view divide for the current axis
  assign div_start    = exec && (uc.op == tvcc_pkg::OP_DIV);
  assign div_dividend = {((uc.axis == tvcc_pkg::AX_Y) ? screen_height : screen_width),
                         {(tvcc_pkg::DIV_W - tvcc_pkg::SCREEN_W){1'b0}}};

  tvcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (zoom),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Clamp and window arithmetic on one axis
  always_comb begin
    cam_w  = {{(tvcc_pkg::AX_W - tvcc_pkg::CAM_W){cam_sel[tvcc_pkg::CAM_W-1]}}, cam_sel};
    view_w = {{(tvcc_pkg::AX_W - tvcc_pkg::VIEW_W){1'b0}}, div_quo};
    half_w = {1'b0, view_w[tvcc_pkg::AX_W-1:1]};
    map_w  = {{(tvcc_pkg::AX_W - tvcc_pkg::MAP_W){1'b0}}, tiles_sel,
              {tvcc_pkg::TILE_SHIFT{1'b0}}};
    lo_w   = (cam_w < half_w) ? half_w : cam_w;
    hi_w   = map_w - half_w;
    if (view_w >= map_w) begin
      clamped = {1'b0, map_w[tvcc_pkg::AX_W-1:1]};
    end else begin
      clamped = (lo_w > hi_w) ? hi_w : lo_w;
    end

    left_w   = cam_w - half_w;
    end_w    = left_w + view_w;
    end_tile = end_w[tvcc_pkg::AX_W-1:tvcc_pkg::TILE_SHIFT] + 1'b1;
    first_new = left_w[tvcc_pkg::AX_W-1] ? '0 :
                left_w[tvcc_pkg::TILE_SHIFT+tvcc_pkg::TILES_W-1:tvcc_pkg::TILE_SHIFT];
    last_new  = (end_tile > {{(tvcc_pkg::END_W - tvcc_pkg::TILES_W){1'b0}}, tiles_sel}) ?
                tiles_sel : end_tile[tvcc_pkg::TILES_W-1:0];

    pan_dy = (btn[tvcc_pkg::BTN_PAN_DOWN] ? tvcc_pkg::PAN_STEP : '0) -
             (btn[tvcc_pkg::BTN_PAN_UP] ? tvcc_pkg::PAN_STEP : '0);
    pan_dx = (btn[tvcc_pkg::BTN_PAN_RIGHT] ? tvcc_pkg::PAN_STEP : '0) -
             (btn[tvcc_pkg::BTN_PAN_LEFT] ? tvcc_pkg::PAN_STEP : '0);
    mul_k  = (uc.op == tvcc_pkg::OP_MUL_UP) ? tvcc_pkg::ZOOM_UP_MUL : tvcc_pkg::ZOOM_DN_MUL;
  end

  // Camera and zoom state
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
      zoom  <= tvcc_pkg::ZOOM_RESET;
    end else if (exec) begin
      unique case (uc.op)
        tvcc_pkg::OP_PAN: begin
          cam_x <= cam_x + pan_dx;
          cam_y <= cam_y + pan_dy;
        end
        tvcc_pkg::OP_SAT_UP: begin
          if (btn[tvcc_pkg::BTN_ZOOM_IN]) begin
            zoom <= tvcc_pkg::zoom_sat(prod[tvcc_pkg::PROD_W-1:12]);
          end
        end
        tvcc_pkg::OP_SAT_DN: begin
          if (btn[tvcc_pkg::BTN_ZOOM_OUT]) begin
            zoom <= tvcc_pkg::zoom_sat(prod[tvcc_pkg::PROD_W-1:12]);
          end
        end
        tvcc_pkg::OP_CLAMP: begin
          if (uc.axis == tvcc_pkg::AX_Y) begin
            cam_y <= clamped[tvcc_pkg::CAM_W-1:0];
          end else begin
            cam_x <= clamped[tvcc_pkg::CAM_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers: buttons, zoom product, tile window
  always_ff @(posedge clk) begin
    if (exec) begin
      unique case (uc.op)
        tvcc_pkg::OP_TAKE: btn <= s_axis_tdata[tvcc_pkg::BTN_COUNT-1:0];
        tvcc_pkg::OP_MUL_UP,
        tvcc_pkg::OP_MUL_DN: begin
          prod <= tvcc_pkg::PROD_W'(zoom) * tvcc_pkg::PROD_W'(mul_k);
        end
        tvcc_pkg::OP_WINDOW: begin
          if (uc.axis == tvcc_pkg::AX_Y) begin
            first_row <= first_new;
            last_row  <= last_new;
          end else begin
            first_col <= first_new;
            last_col  <= last_new;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: load on emit, drop once the receiver takes the word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (exec && (uc.op == tvcc_pkg::OP_EMIT)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && (uc.op == tvcc_pkg::OP_EMIT)) begin
      m_axis_tdata <= {{(tvcc_pkg::M_TDATA_W - tvcc_pkg::M_FIELDS_W){1'b0}},
                       last_row, last_col, first_row, first_col, zoom,
                       cam_y[tvcc_pkg::CAM_OUT_W-1:0], cam_x[tvcc_pkg::CAM_OUT_W-1:0]};
    end
  end

  // Checks
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (exec && uc.op == tvcc_pkg::OP_EMIT) |=> m_axis_tvalid)
    else $error("emit did not load the output register");

  a_cam_clamped: assert property (@(posedge clk) disable iff (rst)
    (exec && uc.op == tvcc_pkg::OP_EMIT) |-> (!cam_x[tvcc_pkg::CAM_W-1] && !cam_y[tvcc_pkg::CAM_W-1]))
    else $error("camera negative at emit");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (uc.op == tvcc_pkg::OP_CLAMP || uc.op == tvcc_pkg::OP_WINDOW) |-> !div_busy)
    else $error("view size used while the divider runs");

  a_zoom_range: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (zoom >= tvcc_pkg::ZOOM_MIN))
    else $error("zoom below its minimum");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (step == tvcc_pkg::L_IDLE + 1'b1))
    else $error("accepted word did not start the program");

endmodule

`default_nettype wire

// ===== tb/tilemap_viewport_clamp_and_cull_core_tb.sv =====
// Self-checking bench for the tilemap viewport core: pan, zoom, map clamp and tile window.
// Needs tvcc_pkg and tilemap_viewport_clamp_and_cull_core; every view word is checked
// against a predictor kept inside the bench or a fixed view word given by a directed row.
`default_nettype none

module tilemap_viewport_clamp_and_cull_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tvcc_pkg::*;

  // One view word as it sits in m_axis_tdata, cam_x in the lowest bits
  typedef struct packed {
    logic [7:0]  last_row;
    logic [7:0]  last_col;
    logic [7:0]  first_row;
    logic [7:0]  first_col;
    logic [11:0] zoom;
    logic [16:0] cam_y;
    logic [16:0] cam_x;
  } view_word_t;

  localparam int VIEW_BITS = $bits(view_word_t);

  typedef enum logic [1:0] {
    ROW_FRAME,
    ROW_KNOWN,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic [5:0]   buttons;
    logic [2:0]   idx;
    logic [11:0]  data;
    view_word_t   want;
  } plan_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_COMB
  } rx_mode_e;

  // Indexes outside the register file
  localparam logic [2:0] REG_SPARE_FIRST = 3'd4;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

  localparam logic [5:0] PRESS_NONE  = 6'd0;
  localparam logic [5:0] PRESS_UP    = 6'd1 << BTN_PAN_UP;
  localparam logic [5:0] PRESS_DOWN  = 6'd1 << BTN_PAN_DOWN;
  localparam logic [5:0] PRESS_LEFT  = 6'd1 << BTN_PAN_LEFT;
  localparam logic [5:0] PRESS_RIGHT = 6'd1 << BTN_PAN_RIGHT;
  localparam logic [5:0] PRESS_ZIN   = 6'd1 << BTN_ZOOM_IN;
  localparam logic [5:0] PRESS_ZOUT  = 6'd1 << BTN_ZOOM_OUT;
  localparam logic [5:0] PRESS_ALL   = 6'h3F;

  localparam int     MUL_SHIFT    = 12;
  localparam longint CAM_CAP      = 131071;
  localparam int     PLAN_LEN     = 40;
  localparam int     RANDOM_ITEMS = 850;
  localparam int     HOLD_AT      = 30;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     TAIL_CYCLES  = 64;
  localparam int     CYCLE_LIMIT  = 400000;

  // Views that follow at once from reset and from an empty map
  localparam view_word_t RESET_VIEW = '{cam_x: 17'd5120, cam_y: 17'd3840, zoom: 12'd256,
                                        first_col: 8'd0, first_row: 8'd0,
                                        last_col: 8'd21, last_row: 8'd16};
  localparam view_word_t VOID_VIEW  = '{cam_x: 17'd0, cam_y: 17'd0, zoom: 12'd256,
                                        first_col: 8'd0, first_row: 8'd0,
                                        last_col: 8'd0, last_row: 8'd0};
  localparam view_word_t VOID_DIP   = '{cam_x: 17'd0, cam_y: 17'd0, zoom: 12'd255,
                                        first_col: 8'd0, first_row: 8'd0,
                                        last_col: 8'd0, last_row: 8'd0};
  localparam view_word_t NO_VIEW    = '0;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;

  tilemap_viewport_clamp_and_cull_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow registers and camera state of the predictor
  logic [11:0] scr_w = SCREEN_W_RESET;
  logic [11:0] scr_h = SCREEN_H_RESET;
  logic [7:0]  map_w = MAP_TILES_RESET;
  logic [7:0]  map_h = MAP_TILES_RESET;
  longint      cam_x_now = 0;
  longint      cam_y_now = 0;
  longint      zoom_now = longint'(ZOOM_RESET);

  view_word_t  pending_views[$];
  plan_row_t   plan [PLAN_LEN];
  int          mismatches = 0;
  int          frames_sent = 0;
  int          views_checked = 0;
  int          regs_written = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  longint      zoom_lo = longint'(ZOOM_RESET);
  longint      zoom_hi = longint'(ZOOM_RESET);
  longint      cam_x_hi = 0;

  // Receiver state
  rx_mode_e    rx_mode = RX_OPEN;
  int          rx_left = 0;
  int          rx_tick = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  function automatic longint clip_zoom(input longint z);
    if (z < longint'(ZOOM_MIN)) return longint'(ZOOM_MIN);
    if (z > longint'(ZOOM_MAX)) return longint'(ZOOM_MAX);
    return z;
  endfunction

  function automatic logic [16:0] cam_field(input longint c);
    if (c < 0) return 17'd0;
    if (c > CAM_CAP) return 17'(CAM_CAP);
    return 17'(c);
  endfunction

  // Centre or clamp one axis, then derive its tile window
  task automatic fit_axis(inout longint cam, input longint screen, input longint tiles,
                          output logic [7:0] first, output logic [7:0] bound);
    longint view, half, tile, map_ext, left, s, e;
    view    = (screen << (8 + FRAC_BITS)) / (zoom_now < 1 ? 1 : zoom_now);
    half    = view >>> 1;
    tile    = longint'(TILE_SIZE) << FRAC_BITS;
    map_ext = tiles * tile;
    if (view >= map_ext) begin
      cam = map_ext >>> 1;
    end else begin
      if (cam < half) cam = half;
      if (cam > map_ext - half) cam = map_ext - half;
    end
    left = cam - half;
    s = left / tile;
    e = (left + view) / tile + 1;
    if (s < 0) s = 0;
    if (e > tiles) e = tiles;
    first = (s > 255) ? 8'd255 : 8'(s);
    bound = (e < 0) ? 8'd0 : ((e > 255) ? 8'd255 : 8'(e));
  endtask

  // Advance the camera by one frame of buttons and form the view word
  task automatic predict_view(input logic [5:0] b, output view_word_t v);
    longint step;
    logic [7:0] fc, lc, fr, lr;
    step = longint'(PAN_STEP);
    if (b[BTN_PAN_UP])    cam_y_now -= step;
    if (b[BTN_PAN_DOWN])  cam_y_now += step;
    if (b[BTN_PAN_LEFT])  cam_x_now -= step;
    if (b[BTN_PAN_RIGHT]) cam_x_now += step;
    if (b[BTN_ZOOM_IN])
      zoom_now = clip_zoom((zoom_now * longint'(ZOOM_UP_MUL)) >>> MUL_SHIFT);
    if (b[BTN_ZOOM_OUT])
      zoom_now = clip_zoom((zoom_now * longint'(ZOOM_DN_MUL)) >>> MUL_SHIFT);
    fit_axis(cam_x_now, longint'(scr_w), longint'(map_w), fc, lc);
    fit_axis(cam_y_now, longint'(scr_h), longint'(map_h), fr, lr);
    v.cam_x     = cam_field(cam_x_now);
    v.cam_y     = cam_field(cam_y_now);
    v.zoom      = zoom_now[11:0];
    v.first_col = fc;
    v.first_row = fr;
    v.last_col  = lc;
    v.last_row  = lr;
    if (zoom_now < zoom_lo) zoom_lo = zoom_now;
    if (zoom_now > zoom_hi) zoom_hi = zoom_now;
    if (cam_x_now > cam_x_hi) cam_x_hi = cam_x_now;
  endtask

  // Offer one button word, with burst gaps; hold tvalid high across back-to-back words
  task automatic offer_frame(input logic [5:0] buttons, input bit known,
                             input view_word_t known_view);
    view_word_t v;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, buttons};
    do @(posedge clk); while (!s_axis_tready);
    predict_view(buttons, v);
    if (known) v = known_view;
    pending_views.push_back(v);
    frames_sent++;
  endtask

  // Stop offering and wait for every outstanding view word
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  // Write one register; the caller drops cfg_valid after the last write of a group
  task automatic put_reg(input logic [2:0] idx, input logic [11:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SCREEN_WIDTH:     scr_w = data;
      REG_SCREEN_HEIGHT:    scr_h = data;
      REG_MAP_WIDTH_TILES:  map_w = data[7:0];
      REG_MAP_HEIGHT_TILES: map_h = data[7:0];
      default: ;
    endcase
    regs_written++;
  endtask

  function automatic logic [11:0] pick_screen();
    case ($urandom_range(0, 15))
      0:       return 12'd0;
      1, 2:    return 12'd1;
      3, 4:    return 12'd4095;
      5, 6, 7: return 12'($urandom_range(1, 4095));
      default: return 12'($urandom_range(64, 1280));
    endcase
  endfunction

  // Map sizes; junk in the upper data bits now and then
  function automatic logic [11:0] pick_tiles();
    logic [11:0] t;
    case ($urandom_range(0, 15))
      0:          t = 12'd0;
      1, 2:       t = 12'd1;
      3, 4:       t = 12'd255;
      5, 6, 7, 8: t = 12'($urandom_range(1, 16));
      default:    t = 12'($urandom_range(1, 255));
    endcase
    if ($urandom_range(0, 3) == 0) t[11:8] = 4'($urandom);
    return t;
  endfunction

  task automatic roll_settings();
    quiesce();
    put_reg(REG_SCREEN_WIDTH, pick_screen());
    put_reg(REG_SCREEN_HEIGHT, pick_screen());
    put_reg(REG_MAP_WIDTH_TILES, pick_tiles());
    put_reg(REG_MAP_HEIGHT_TILES, pick_tiles());
    if ($urandom_range(0, 3) == 0)
      put_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 12'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Biased buttons: a phase may lean one way in pan and zoom, with some noise words
  function automatic logic [5:0] roll_buttons(input int zoom_mode, input int h_dir,
                                              input int v_dir);
    logic [5:0] b;
    b = '0;
    if ($urandom_range(0, 7) == 0) return 6'($urandom);
    b[BTN_PAN_RIGHT] = $urandom_range(0, 7) < ((h_dir == 1) ? 6 : 2);
    b[BTN_PAN_LEFT]  = $urandom_range(0, 7) < ((h_dir == 2) ? 6 : 2);
    b[BTN_PAN_DOWN]  = $urandom_range(0, 7) < ((v_dir == 1) ? 6 : 2);
    b[BTN_PAN_UP]    = $urandom_range(0, 7) < ((v_dir == 2) ? 6 : 2);
    b[BTN_ZOOM_IN]   = $urandom_range(0, 7) < ((zoom_mode == 1) ? 6 :
                                               (zoom_mode == 2) ? 1 : 2);
    b[BTN_ZOOM_OUT]  = $urandom_range(0, 7) < ((zoom_mode == 2) ? 6 :
                                               (zoom_mode == 1) ? 1 : 2);
    return b;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: view %0d %s expected %0d got %0d", $time, views_checked, name,
               want, got);
      mismatches++;
    end
  endtask

  // Check accepted view words and drive the receiver's stall pattern
  always @(posedge clk) begin
    view_word_t got, want;
    bit ready_next;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = view_word_t'(m_axis_tdata[VIEW_BITS-1:0]);
        if (pending_views.size() == 0) begin
          $display("%0t: unexpected view word %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = pending_views.pop_front();
          check_field("cam_x", want.cam_x, got.cam_x);
          check_field("cam_y", want.cam_y, got.cam_y);
          check_field("zoom_level", want.zoom, got.zoom);
          check_field("first_col", want.first_col, got.first_col);
          check_field("first_row", want.first_row, got.first_row);
          check_field("last_col", want.last_col, got.last_col);
          check_field("last_row", want.last_row, got.last_row);
          check_field("pad", 0, m_axis_tdata[M_TDATA_W-1:VIEW_BITS]);
          views_checked++;
        end
      end
      // one long hold-off so the core fills up and stalls its input
      if (!hold_done && frames_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 200);
      end else begin
        rx_left--;
      end
      rx_tick++;
      if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   ready_next = 1'b1;
          RX_COIN:   ready_next = $urandom_range(0, 1);
          RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
          default:   ready_next = (rx_tick % 3) != 0;
        endcase
      end
      m_axis_tready <= ready_next;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d view words outstanding", $time,
               pending_views.size());
      $display("[tilemap_viewport_clamp_and_cull_core] ERROR");
      $finish;
    end
  end

  initial begin
    int random_frames;
    int phase_len, zoom_mode, h_dir, v_dir;

    // Directed rows: reset view, empty map, single buttons, extreme settings
    plan = '{
      '{ROW_KNOWN, PRESS_NONE,               REG_SCREEN_WIDTH,     12'd0,    RESET_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_MAP_WIDTH_TILES,  12'd0,    NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_MAP_HEIGHT_TILES, 12'd0,    NO_VIEW},
      '{ROW_KNOWN, PRESS_NONE,               REG_SCREEN_WIDTH,     12'd0,    VOID_VIEW},
      '{ROW_KNOWN, PRESS_ALL,                REG_SCREEN_WIDTH,     12'd0,    VOID_DIP},
      '{ROW_REG,   PRESS_NONE,               REG_MAP_WIDTH_TILES,  12'd255,  NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_MAP_HEIGHT_TILES, 12'd255,  NO_VIEW},
      '{ROW_FRAME, PRESS_RIGHT,              REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_FRAME, PRESS_DOWN,               REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_FRAME, PRESS_LEFT | PRESS_DOWN,  REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_FRAME, PRESS_UP,                 REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_FRAME, PRESS_ZIN,                REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_FRAME, PRESS_ZOUT,               REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_FRAME, PRESS_UP | PRESS_DOWN,    REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_SCREEN_HEIGHT,    12'd0,    NO_VIEW},
      '{ROW_FRAME, PRESS_RIGHT | PRESS_DOWN, REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_FRAME, PRESS_LEFT | PRESS_UP,    REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_MAP_WIDTH_TILES,  12'd0,    NO_VIEW},
      '{ROW_FRAME, PRESS_NONE,               REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_SCREEN_WIDTH,     12'd4095, NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_SCREEN_HEIGHT,    12'd4095, NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_MAP_WIDTH_TILES,  12'd255,  NO_VIEW},
      '{ROW_FRAME, PRESS_ZOUT,               REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_FRAME, PRESS_RIGHT | PRESS_ZIN,  REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_SPARE_LAST,       12'd4095, NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_SPARE_FIRST,      12'd0,    NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_SCREEN_WIDTH,     12'd1,    NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_SCREEN_HEIGHT,    12'd1,    NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_MAP_WIDTH_TILES,  12'd1,    NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_MAP_HEIGHT_TILES, 12'd1,    NO_VIEW},
      '{ROW_FRAME, PRESS_RIGHT | PRESS_DOWN, REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_FRAME, PRESS_ZIN | PRESS_ZOUT,   REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_MAP_WIDTH_TILES,  12'h7FF,  NO_VIEW},
      '{ROW_FRAME, PRESS_RIGHT,              REG_SCREEN_WIDTH,     12'd0,    NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_SCREEN_WIDTH,     12'd640,  NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_SCREEN_HEIGHT,    12'd480,  NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_MAP_WIDTH_TILES,  12'd50,   NO_VIEW},
      '{ROW_REG,   PRESS_NONE,               REG_MAP_HEIGHT_TILES, 12'd50,   NO_VIEW},
      '{ROW_FRAME, PRESS_NONE,               REG_SCREEN_WIDTH,     12'd0,    NO_VIEW}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed rows; register groups go in only once the core is drained
    for (int r = 0; r < PLAN_LEN; r++) begin
      if (plan[r].kind == ROW_REG) begin
        if (r == 0 || plan[r - 1].kind != ROW_REG) quiesce();
        put_reg(plan[r].idx, plan[r].data);
        if (r == PLAN_LEN - 1 || plan[r + 1].kind != ROW_REG) cfg_valid <= 1'b0;
      end else begin
        offer_frame(plan[r].buttons, plan[r].kind == ROW_KNOWN, plan[r].want);
      end
    end

    // Random phases: the first keeps the reset settings so the long hold-off lands in it
    random_frames = 0;
    while (random_frames < RANDOM_ITEMS) begin
      if (random_frames != 0) roll_settings();
      phase_len = $urandom_range(25, 70);
      zoom_mode = $urandom_range(0, 2);
      h_dir     = $urandom_range(0, 2);
      v_dir     = $urandom_range(0, 2);
      repeat (phase_len) begin
        offer_frame(roll_buttons(zoom_mode, h_dir, v_dir), 1'b0, NO_VIEW);
        random_frames++;
      end
    end

    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d frames (%0d random) across %0d register writes; checked %0d views.",
             frames_sent, random_frames, regs_written, views_checked);
    $display("Zoom swept %0d to %0d; camera x reached %0d.", zoom_lo, zoom_hi, cam_x_hi);
    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("[tilemap_viewport_clamp_and_cull_core] OK");
    end else begin
      $display("[tilemap_viewport_clamp_and_cull_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
